@@ rtl/core/lcbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED colour engine package
// Shared types, codes and constants of the blink and palette fade engine.
// ----------------------------------------------------------------------------
package lcbf_pkg;

	localparam int unsigned PAL_DEPTH = 4;
	localparam int unsigned PAL_IDX_W = $clog2(PAL_DEPTH);
	localparam int unsigned COLOR_W   = 24;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned FRAC_W    = 25;
	localparam int unsigned TMR_W     = 33;
	localparam int unsigned DT_W      = 16;
	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned IVAL_W    = 32;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned PROD_W    = CHAN_W + FRAC_W;
	localparam int unsigned INCR_W    = DT_W + SPEED_W;

	localparam logic [FRAC_W-1:0]  FRAC_ONE   = 25'h100_0000;
	localparam logic [FRAC_W-1:0]  FRAC_MAX   = 25'h1FF_FFFF;
	localparam logic [PROD_W:0]    FRAC_HALF  = 34'h00_0080_0000;
	localparam logic [COLOR_W-1:0] WHITE      = 24'hFF_FFFF;
	localparam logic [COLOR_W-1:0] BLACK      = 24'h00_0000;
	localparam logic [SPEED_W-1:0] SPEED_RST  = 16'h0100;
	localparam logic [CNT_W-1:0]   COUNT_RST  = 3'd1;
	localparam logic [CNT_W-1:0]   COUNT_MAX  = CNT_W'(PAL_DEPTH);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK          = 3'd0,
		REQ_BLINK_START   = 3'd1,
		REQ_BLINK_STOP    = 3'd2,
		REQ_FADE_START    = 3'd3,
		REQ_FADE_STOP     = 3'd4,
		REQ_LIGHT_OFF     = 3'd5,
		REQ_INIT          = 3'd6,
		REQ_FADE_RESTART  = 3'd7
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLINK_INTERVAL = 3'd0,
		CFG_FADE_SPEED     = 3'd1,
		CFG_PALETTE_COUNT  = 3'd2,
		CFG_PALETTE_0      = 3'd3,
		CFG_PALETTE_1      = 3'd4,
		CFG_PALETTE_2      = 3'd5,
		CFG_PALETTE_3      = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_FRAC,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_LAST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  accept;
		logic  step_inc;
		logic  step_frac;
		logic  mul_en;
		chan_t mul_sel;
		logic  wr_en;
		chan_t wr_sel;
		logic  fade_end;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic started;
		logic fade_on;
	} status_t;

endpackage

@@ rtl/core/lcbf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED colour engine channels
// Request and result channels with valid and ready handshake.
// ----------------------------------------------------------------------------
interface lcbf_req_if;
	logic                          valid;
	logic                          ready;
	logic [lcbf_pkg::REQ_W-1:0]    req_type;
	logic [lcbf_pkg::DT_W-1:0]     delta_time;

	modport source (output valid, output req_type, output delta_time, input ready);
	modport sink (input valid, input req_type, input delta_time, output ready);
endinterface

interface lcbf_res_if;
	logic                          valid;
	logic                          ready;
	logic [lcbf_pkg::CHAN_W-1:0]   red;
	logic [lcbf_pkg::CHAN_W-1:0]   green;
	logic [lcbf_pkg::CHAN_W-1:0]   blue;
	logic                          light_on;
	logic                          blink_active;
	logic                          fade_active;

	modport source (output valid, output red, output green, output blue,
		output light_on, output blink_active, output fade_active, input ready);
	modport sink (input valid, input red, input green, input blue,
		input light_on, input blink_active, input fade_active, output ready);
endinterface

@@ rtl/core/lcbf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED colour engine controller
// Sequences each request word through the datapath and owns the result valid.
// ----------------------------------------------------------------------------
module lcbf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lcbf_pkg::REQ_W-1:0]  in_req_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  lcbf_pkg::status_t           sts,
	output lcbf_pkg::cmd_t              cmd
);

	lcbf_pkg::state_t state_q;
	lcbf_pkg::state_t state_nxt;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcbf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			lcbf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (lcbf_pkg::req_t'(in_req_type) == lcbf_pkg::REQ_TICK && sts.started) begin
						state_nxt = lcbf_pkg::ST_INC;
					end else begin
						state_nxt = lcbf_pkg::ST_DONE;
					end
				end
			end
			lcbf_pkg::ST_INC: begin
				cmd.step_inc = 1'b1;
				state_nxt    = sts.fade_on ? lcbf_pkg::ST_FRAC : lcbf_pkg::ST_DONE;
			end
			lcbf_pkg::ST_FRAC: begin
				cmd.step_frac = 1'b1;
				state_nxt     = lcbf_pkg::ST_MUL0;
			end
			lcbf_pkg::ST_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = lcbf_pkg::CH_RED;
				state_nxt   = lcbf_pkg::ST_MUL1;
			end
			lcbf_pkg::ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = lcbf_pkg::CH_GREEN;
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = lcbf_pkg::CH_RED;
				state_nxt   = lcbf_pkg::ST_MUL2;
			end
			lcbf_pkg::ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = lcbf_pkg::CH_BLUE;
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = lcbf_pkg::CH_GREEN;
				state_nxt   = lcbf_pkg::ST_LAST;
			end
			lcbf_pkg::ST_LAST: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = lcbf_pkg::CH_BLUE;
				cmd.fade_end = 1'b1;
				state_nxt    = lcbf_pkg::ST_DONE;
			end
			lcbf_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = lcbf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lcbf_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/lcbf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED colour engine datapath
// Configuration, light state, blink timer, fade fraction and the shared
// channel multiplier for palette interpolation.
// ----------------------------------------------------------------------------
module lcbf_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lcbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcbf_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic [lcbf_pkg::REQ_W-1:0]      in_req_type,
	input  logic [lcbf_pkg::DT_W-1:0]       in_delta_time,
	input  lcbf_pkg::cmd_t                  cmd,
	output lcbf_pkg::status_t               sts,
	output logic [lcbf_pkg::CHAN_W-1:0]     red,
	output logic [lcbf_pkg::CHAN_W-1:0]     green,
	output logic [lcbf_pkg::CHAN_W-1:0]     blue,
	output logic                            light_on,
	output logic                            blink_active,
	output logic                            fade_active
);

	logic [lcbf_pkg::IVAL_W-1:0]    interval_q;
	logic [lcbf_pkg::SPEED_W-1:0]   speed_q;
	logic [lcbf_pkg::CNT_W-1:0]     count_q;
	logic [lcbf_pkg::COLOR_W-1:0]   pal_q [lcbf_pkg::PAL_DEPTH];

	logic [lcbf_pkg::COLOR_W-1:0]   cur_q;
	logic [lcbf_pkg::COLOR_W-1:0]   alt_q;
	logic [lcbf_pkg::COLOR_W-1:0]   sav_q;
	logic [lcbf_pkg::TMR_W-1:0]     btmr_q;
	logic                           blink_on_q;
	logic                           fade_on_q;
	logic [lcbf_pkg::FRAC_W-1:0]    frac_q;
	logic [lcbf_pkg::PAL_IDX_W-1:0] idx_q;
	logic                           started_q;
	logic                           lit_q;

	logic [lcbf_pkg::DT_W-1:0]      dt_q;
	logic [lcbf_pkg::INCR_W-1:0]    incr_q;
	logic [lcbf_pkg::COLOR_W-1:0]   pa_q;
	logic [lcbf_pkg::COLOR_W-1:0]   pb_q;
	logic [lcbf_pkg::PROD_W-1:0]    prod_q;
	logic                           neg_q;
	logic [lcbf_pkg::CHAN_W-1:0]    base_q;

	logic [lcbf_pkg::CHAN_W-1:0]    red_q;
	logic [lcbf_pkg::CHAN_W-1:0]    green_q;
	logic [lcbf_pkg::CHAN_W-1:0]    blue_q;
	logic                           light_on_q;
	logic                           blink_act_q;
	logic                           fade_act_q;

	logic [lcbf_pkg::CNT_W-1:0]     n_used;
	logic [lcbf_pkg::PAL_IDX_W-1:0] idx_eff;
	logic [lcbf_pkg::CNT_W-1:0]     idx_inc;
	logic [lcbf_pkg::PAL_IDX_W-1:0] idx_nxt;
	logic [lcbf_pkg::PAL_IDX_W-1:0] rd_addr;
	logic [lcbf_pkg::COLOR_W-1:0]   rd_data;
	logic [lcbf_pkg::TMR_W-1:0]     bsum;
	logic [lcbf_pkg::TMR_W-1:0]     fsum;
	logic [lcbf_pkg::CHAN_W-1:0]    ch_a;
	logic [lcbf_pkg::CHAN_W-1:0]    ch_b;
	logic                           ch_neg;
	logic [lcbf_pkg::CHAN_W-1:0]    ch_mag;
	logic [lcbf_pkg::PROD_W:0]      rnd;
	logic [9:0]                     rmag;
	logic [10:0]                    psum;
	logic [lcbf_pkg::CHAN_W-1:0]    ch_res;

	function automatic logic [lcbf_pkg::CHAN_W-1:0] chan_of(
		input logic [lcbf_pkg::COLOR_W-1:0] c,
		input lcbf_pkg::chan_t              sel
	);
		logic [lcbf_pkg::CHAN_W-1:0] b;
		case (sel)
			lcbf_pkg::CH_RED:   b = c[23:16];
			lcbf_pkg::CH_GREEN: b = c[15:8];
			lcbf_pkg::CH_BLUE:  b = c[7:0];
			default:            b = '0;
		endcase
		return b;
	endfunction

	// Palette count is clamped to the range one to the palette depth.
	always_comb begin
		if (count_q == '0) begin
			n_used = lcbf_pkg::CNT_W'(1);
		end else if (count_q > lcbf_pkg::COUNT_MAX) begin
			n_used = lcbf_pkg::COUNT_MAX;
		end else begin
			n_used = count_q;
		end
		idx_eff = ({1'b0, idx_q} >= n_used) ? '0 : idx_q;
		idx_inc = {1'b0, idx_q} + lcbf_pkg::CNT_W'(1);
		idx_nxt = (idx_inc >= n_used) ? '0 : idx_inc[lcbf_pkg::PAL_IDX_W-1:0];
		rd_addr = cmd.step_inc ? idx_eff : idx_nxt;
		rd_data = pal_q[rd_addr];
	end

	always_comb begin
		bsum   = btmr_q + lcbf_pkg::TMR_W'(dt_q);
		fsum   = lcbf_pkg::TMR_W'(frac_q) + lcbf_pkg::TMR_W'(incr_q);
		ch_a   = chan_of(pa_q, cmd.mul_sel);
		ch_b   = chan_of(pb_q, cmd.mul_sel);
		ch_neg = ch_b < ch_a;
		ch_mag = ch_neg ? (ch_a - ch_b) : (ch_b - ch_a);
		// Rounding to nearest on the magnitude gives ties away from zero.
		rnd    = {1'b0, prod_q} + lcbf_pkg::FRAC_HALF;
		rmag   = rnd[lcbf_pkg::PROD_W:24];
		psum   = {3'b000, base_q} + {1'b0, rmag};
		if (neg_q) begin
			ch_res = (rmag > {2'b00, base_q}) ? '0 : (base_q - rmag[7:0]);
		end else begin
			ch_res = (psum > 11'd255) ? 8'hFF : psum[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			speed_q    <= lcbf_pkg::SPEED_RST;
			count_q    <= lcbf_pkg::COUNT_RST;
			for (int i = 0; i < lcbf_pkg::PAL_DEPTH; i++) begin
				pal_q[i] <= lcbf_pkg::WHITE;
			end
		end else if (cfg_we) begin
			case (lcbf_pkg::cfg_idx_t'(cfg_index))
				lcbf_pkg::CFG_BLINK_INTERVAL: interval_q <= cfg_data[lcbf_pkg::IVAL_W-1:0];
				lcbf_pkg::CFG_FADE_SPEED:     speed_q    <= cfg_data[lcbf_pkg::SPEED_W-1:0];
				lcbf_pkg::CFG_PALETTE_COUNT:  count_q    <= cfg_data[lcbf_pkg::CNT_W-1:0];
				lcbf_pkg::CFG_PALETTE_0:      pal_q[0]   <= cfg_data[lcbf_pkg::COLOR_W-1:0];
				lcbf_pkg::CFG_PALETTE_1:      pal_q[1]   <= cfg_data[lcbf_pkg::COLOR_W-1:0];
				lcbf_pkg::CFG_PALETTE_2:      pal_q[2]   <= cfg_data[lcbf_pkg::COLOR_W-1:0];
				lcbf_pkg::CFG_PALETTE_3:      pal_q[3]   <= cfg_data[lcbf_pkg::COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= lcbf_pkg::WHITE;
			alt_q       <= lcbf_pkg::BLACK;
			sav_q       <= lcbf_pkg::BLACK;
			btmr_q      <= '0;
			blink_on_q  <= 1'b0;
			fade_on_q   <= 1'b0;
			frac_q      <= '0;
			idx_q       <= '0;
			started_q   <= 1'b0;
			lit_q       <= 1'b1;
			light_on_q  <= 1'b0;
			blink_act_q <= 1'b0;
			fade_act_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (lcbf_pkg::req_t'(in_req_type))
					lcbf_pkg::REQ_TICK: begin
					end
					lcbf_pkg::REQ_BLINK_START: begin
						btmr_q     <= '0;
						alt_q      <= lcbf_pkg::BLACK;
						sav_q      <= cur_q;
						blink_on_q <= 1'b1;
					end
					lcbf_pkg::REQ_BLINK_STOP: begin
						if (blink_on_q) begin
							cur_q      <= sav_q;
							blink_on_q <= 1'b0;
						end
					end
					lcbf_pkg::REQ_FADE_START: fade_on_q <= 1'b1;
					lcbf_pkg::REQ_FADE_STOP:  fade_on_q <= 1'b0;
					lcbf_pkg::REQ_LIGHT_OFF: begin
						cur_q <= lcbf_pkg::BLACK;
						lit_q <= 1'b0;
					end
					lcbf_pkg::REQ_INIT: begin
						cur_q     <= lcbf_pkg::WHITE;
						started_q <= 1'b1;
						lit_q     <= 1'b1;
					end
					lcbf_pkg::REQ_FADE_RESTART: begin
						frac_q    <= '0;
						idx_q     <= '0;
						fade_on_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.step_inc) begin
				if (blink_on_q) begin
					if (bsum > lcbf_pkg::TMR_W'(interval_q)) begin
						cur_q  <= alt_q;
						alt_q  <= cur_q;
						btmr_q <= '0;
					end else begin
						btmr_q <= bsum;
					end
				end
				if (fade_on_q) begin
					idx_q <= idx_eff;
				end
			end
			if (cmd.step_frac) begin
				frac_q <= (fsum > lcbf_pkg::TMR_W'(lcbf_pkg::FRAC_MAX)) ?
					lcbf_pkg::FRAC_MAX : fsum[lcbf_pkg::FRAC_W-1:0];
			end
			if (cmd.wr_en) begin
				case (cmd.wr_sel)
					lcbf_pkg::CH_RED:   cur_q[23:16] <= ch_res;
					lcbf_pkg::CH_GREEN: cur_q[15:8]  <= ch_res;
					lcbf_pkg::CH_BLUE:  cur_q[7:0]   <= ch_res;
					default: begin
					end
				endcase
			end
			if (cmd.fade_end && frac_q > lcbf_pkg::FRAC_ONE) begin
				frac_q <= '0;
				idx_q  <= idx_nxt;
			end
			if (cmd.load_out) begin
				light_on_q  <= started_q && lit_q;
				blink_act_q <= blink_on_q;
				fade_act_q  <= fade_on_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dt_q <= in_delta_time;
		end
		if (cmd.step_inc) begin
			incr_q <= dt_q * speed_q;
			pa_q   <= rd_data;
		end
		if (cmd.step_frac) begin
			pb_q <= rd_data;
		end
		if (cmd.mul_en) begin
			prod_q <= ch_mag * frac_q;
			neg_q  <= ch_neg;
			base_q <= ch_a;
		end
		if (cmd.load_out) begin
			red_q   <= cur_q[23:16];
			green_q <= cur_q[15:8];
			blue_q  <= cur_q[7:0];
		end
	end

	assign sts.started  = started_q;
	assign sts.fade_on  = fade_on_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign light_on     = light_on_q;
	assign blink_active = blink_act_q;
	assign fade_active  = fade_act_q;

endmodule

@@ rtl/core/led_color_blink_fade_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED colour blink and fade engine
// Holds one RGB light colour and updates it from frame ticks and commands.
// ----------------------------------------------------------------------------
// Every request word gives exactly one result word with the light state after
// the request. A command, or a tick before the light is initialised, goes from
// idle straight to the done state, a tick without fading passes the increment
// state, and a tick while fading the increment, fraction, multiply and last
// states. The result word becomes valid in the same cycle as the controller
// is back in idle. A fading tick runs the blink step, the fraction update
// from its own increment multiplier, and the three channel products that go
// through one shared multiplier in turn. A finished result waits in the
// controller while the previous result word is still held at the output. A
// new request is taken once the controller is back in idle, even while the
// previous result still waits at the output. No clearing pass follows reset.
module led_color_blink_fade_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	lcbf_req_if.sink                        req,
	lcbf_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [lcbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcbf_pkg::CFG_DAT_W-1:0]  cfg_data
);

	lcbf_pkg::cmd_t    cmd;
	lcbf_pkg::status_t sts;

	lcbf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_req_type (req.req_type),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	lcbf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_req_type   (req.req_type),
		.in_delta_time (req.delta_time),
		.cmd           (cmd),
		.sts           (sts),
		.red           (res.red),
		.green         (res.green),
		.blue          (res.blue),
		.light_on      (res.light_on),
		.blink_active  (res.blink_active),
		.fade_active   (res.fade_active)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED colour engine testbench
// Sends request words and register writes to the blink and fade engine. A
// model of the light state in this bench predicts each result word the script
// does not give, and the words that come back are compared in order. A short
// script covers the commands and corner cases. Random phases with fresh
// register settings follow, with idle bursts on both channels when not calm.
// ----------------------------------------------------------------------------
module testbench;
	import lcbf_pkg::*;

	localparam int HALF_HIGH = 6;
	localparam int HALF_LOW = 6;
	localparam int RESET_CYCLES = 10;
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD = 400;
	localparam int LINGER = 20;
	localparam int PHASES = 14;
	localparam int PHASE_WORDS = 100;
	localparam int CALM_PHASES = 2;
	localparam int PRESSURE_PHASE = 2;
	localparam int MAX_REPORTS = 10;
	localparam int SCRIPT_ROWS = 38;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              light_on;
		logic              blink_active;
		logic              fade_active;
	} light_word_t;

	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_DAT_W-1:0] reg_val;
		req_t                 kind;
		logic [DT_W-1:0]      dt;
		bit                   typed;
		light_word_t          want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	lcbf_req_if req_if ();
	lcbf_res_if res_if ();

	led_color_blink_fade_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Registers and light state as the engine should hold them.
	logic [IVAL_W-1:0]    ival_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [CNT_W-1:0]     count_q;
	logic [COLOR_W-1:0]   pal_q [PAL_DEPTH];
	logic [COLOR_W-1:0]   cur_col;
	logic [COLOR_W-1:0]   alt_col;
	logic [COLOR_W-1:0]   sav_col;
	logic [TMR_W-1:0]     blink_tmr;
	logic [FRAC_W-1:0]    frac_q;
	logic [PAL_IDX_W-1:0] pal_idx;
	bit                   blink_on_q;
	bit                   fade_on_q;
	bit                   started_q;
	bit                   lit_q;

	light_word_t pending_light_q [$];
	int          mismatches;
	bit          calm;
	bit          long_hold_req;

	script_row_t script_rows [SCRIPT_ROWS] = '{
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b1, {24'hFFFFFF, 3'b000}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_BLINK_STOP,   16'h0000, 1'b1, {24'hFFFFFF, 3'b000}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_INIT,         16'h0000, 1'b1, {24'hFFFFFF, 3'b100}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_BLINK_START,  16'h0000, 1'b1, {24'hFFFFFF, 3'b110}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'h0000, 1'b1, {24'hFFFFFF, 3'b110}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'h0001, 1'b1, {24'h000000, 3'b110}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b1, {24'hFFFFFF, 3'b110}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_BLINK_STOP,   16'h0000, 1'b1, {24'hFFFFFF, 3'b100}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_LIGHT_OFF,    16'h0000, 1'b1, {24'h000000, 3'b000}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_INIT,         16'h0000, 1'b1, {24'hFFFFFF, 3'b100}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_FADE_START,   16'h0000, 1'b1, {24'hFFFFFF, 3'b101}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b1, {24'hFFFFFF, 3'b101}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b1, {24'hFFFFFF, 3'b101}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_FADE_STOP,    16'h0000, 1'b1, {24'hFFFFFF, 3'b100}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_FADE_RESTART, 16'h0000, 1'b1, {24'hFFFFFF, 3'b101}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_LIGHT_OFF,    16'h0000, 1'b1, {24'h000000, 3'b001}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'h0000, 1'b1, {24'hFFFFFF, 3'b001}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_INIT,         16'h0000, 1'b1, {24'hFFFFFF, 3'b101}},
		'{1'b1, CFG_PALETTE_COUNT,  32'hFFFF_FFFA, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_PALETTE_0,      32'hFF00_0000, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_PALETTE_1,      32'hFFFF_FFFF, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_FADE_SPEED,     32'hFFFF_FFFF, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_FADE_RESTART, 16'h0000, 1'b1, {24'hFFFFFF, 3'b101}},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'h0001, 1'b0, '0},
		'{1'b1, CFG_PALETTE_COUNT,  32'h0000_0000, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_UNUSED,         32'hFFFF_FFFF, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_BLINK_INTERVAL, 32'hFFFF_FFFF, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_FADE_SPEED,     32'h0000_0000, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'h8000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_FADE_STOP,    16'h0000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_BLINK_START,  16'h0000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b0, '0},
		'{1'b1, CFG_PALETTE_COUNT,  32'h0000_0007, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b1, CFG_FADE_SPEED,     32'h0000_0001, REQ_TICK, 16'h0000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_FADE_START,   16'h0000, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_TICK,         16'hFFFF, 1'b0, '0},
		'{1'b0, CFG_BLINK_INTERVAL, 32'h0, REQ_BLINK_STOP,   16'h0000, 1'b0, '0}
	};

	always begin
		clk = 1'b0;
		#HALF_LOW;
		clk = 1'b1;
		#HALF_HIGH;
	end

	function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] a,
		logic [CHAN_W-1:0] b, logic [FRAC_W-1:0] t);
		longint prod;
		longint half;
		longint delta;
		longint level;
		half = longint'(FRAC_ONE) / 2;
		prod = (longint'(b) - longint'(a)) * longint'(t);
		if (prod >= 0) begin
			delta = (prod + half) >>> 24;
		end else begin
			delta = -((-prod + half) >>> 24);
		end
		level = longint'(a) + delta;
		if (level < 0) begin
			level = 0;
		end
		if (level > 255) begin
			level = 255;
		end
		return level[CHAN_W-1:0];
	endfunction

	function automatic light_word_t advance_light(req_t kind, logic [DT_W-1:0] dt);
		logic [COLOR_W-1:0] swap;
		logic [COLOR_W-1:0] src_col;
		logic [COLOR_W-1:0] dst_col;
		longint unsigned    sum;
		int unsigned        span;
		int unsigned        nxt;
		case (kind)
		REQ_TICK: if (started_q) begin
			if (blink_on_q) begin
				blink_tmr = blink_tmr + dt;
				if (blink_tmr > TMR_W'(ival_q)) begin
					swap = cur_col;
					cur_col = alt_col;
					alt_col = swap;
					blink_tmr = '0;
				end
			end
			if (fade_on_q) begin
				sum = 64'(frac_q) + 64'(dt) * 64'(speed_q);
				if (sum > 64'(FRAC_MAX)) begin
					sum = 64'(FRAC_MAX);
				end
				frac_q = sum[FRAC_W-1:0];
				span = (count_q == 0) ? 1 : (count_q > PAL_DEPTH) ? PAL_DEPTH : count_q;
				if (pal_idx >= span) begin
					pal_idx = '0;
				end
				nxt = (pal_idx + 1 >= span) ? 0 : pal_idx + 1;
				src_col = pal_q[pal_idx];
				dst_col = pal_q[nxt];
				cur_col = {blend_chan(src_col[23:16], dst_col[23:16], frac_q),
					blend_chan(src_col[15:8], dst_col[15:8], frac_q),
					blend_chan(src_col[7:0], dst_col[7:0], frac_q)};
				if (frac_q > FRAC_ONE) begin
					frac_q = '0;
					pal_idx = PAL_IDX_W'(nxt);
				end
			end
		end
		REQ_BLINK_START: begin
			blink_tmr = '0;
			alt_col = BLACK;
			sav_col = cur_col;
			blink_on_q = 1'b1;
		end
		REQ_BLINK_STOP: if (blink_on_q) begin
			cur_col = sav_col;
			blink_on_q = 1'b0;
		end
		REQ_FADE_START: fade_on_q = 1'b1;
		REQ_FADE_STOP: fade_on_q = 1'b0;
		REQ_LIGHT_OFF: begin
			cur_col = BLACK;
			lit_q = 1'b0;
		end
		REQ_INIT: begin
			cur_col = WHITE;
			started_q = 1'b1;
			lit_q = 1'b1;
		end
		default: begin
			frac_q = '0;
			pal_idx = '0;
			fade_on_q = 1'b1;
		end
		endcase
		return {cur_col, started_q && lit_q, blink_on_q, fade_on_q};
	endfunction

	// Waits until every result word is back, so the engine is idle, then writes the register and mirrors it in the model.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		req_if.valid <= 1'b0;
		while (pending_light_q.size() != 0) begin
			@(posedge clk);
		end
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_BLINK_INTERVAL: ival_q = val;
		CFG_FADE_SPEED: speed_q = val[SPEED_W-1:0];
		CFG_PALETTE_COUNT: count_q = val[CNT_W-1:0];
		CFG_PALETTE_0: pal_q[0] = val[COLOR_W-1:0];
		CFG_PALETTE_1: pal_q[1] = val[COLOR_W-1:0];
		CFG_PALETTE_2: pal_q[2] = val[COLOR_W-1:0];
		CFG_PALETTE_3: pal_q[3] = val[COLOR_W-1:0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_word(req_t kind, logic [DT_W-1:0] dt, bit typed,
		light_word_t typed_want);
		light_word_t predicted;
		bit          took;
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.delta_time <= dt;
		do begin
			@(negedge clk);
			took = req_if.ready;
			@(posedge clk);
		end while (!took);
		predicted = advance_light(kind, dt);
		pending_light_q.push_back(typed ? typed_want : predicted);
	endtask

	initial begin : result_sink
		light_word_t seen;
		light_word_t want;
		bit          got;
		int          hold;
		res_if.ready <= 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			got = res_if.valid && res_if.ready;
			seen = {res_if.red, res_if.green, res_if.blue, res_if.light_on,
				res_if.blink_active, res_if.fade_active};
			@(posedge clk);
			if (got) begin
				if (pending_light_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: unexpected result word rgb %h %h %h flags %b%b%b",
							$time, seen.red, seen.green, seen.blue, seen.light_on,
							seen.blink_active, seen.fade_active);
					end
				end else begin
					want = pending_light_q.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected rgb %h %h %h on %b blink %b fade %b",
								$time, want.red, want.green, want.blue, want.light_on,
								want.blink_active, want.fade_active);
							$display("%0t: actual   rgb %h %h %h on %b blink %b fade %b",
								$time, seen.red, seen.green, seen.blue, seen.light_on,
								seen.blink_active, seen.fade_active);
						end
					end
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 15);
			end
			if (hold > 0) begin
				hold--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("led_color_blink_fade_engine: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_DAT_W-1:0] val;
		logic [DT_W-1:0]      dt;
		req_t                 kind;
		int                   pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_TICK;
		req_if.delta_time <= '0;
		mismatches = 0;
		calm = 1'b0;
		long_hold_req = 1'b0;
		ival_q = '0;
		speed_q = SPEED_RST;
		count_q = COUNT_RST;
		foreach (pal_q[i]) begin
			pal_q[i] = WHITE;
		end
		cur_col = WHITE;
		alt_col = BLACK;
		sav_col = BLACK;
		blink_tmr = '0;
		frac_q = '0;
		pal_idx = '0;
		blink_on_q = 1'b0;
		fade_on_q = 1'b0;
		started_q = 1'b0;
		lit_q = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_rows[i]) begin
			if (script_rows[i].is_reg) begin
				write_reg(script_rows[i].reg_idx, script_rows[i].reg_val);
			end else begin
				send_word(script_rows[i].kind, script_rows[i].dt, script_rows[i].typed,
					script_rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int r = 0; r <= CFG_UNUSED; r++) begin
				if (ph != 0 && $urandom_range(0, 3) == 0) begin
					continue;
				end
				val = $urandom;
				pick = $urandom_range(0, 3);
				case (r)
				CFG_BLINK_INTERVAL: begin
					if (pick == 0) begin
						val = '0;
					end else if (pick == 1) begin
						val = '1;
					end else if (pick == 2) begin
						val = $urandom_range(0, 4000);
					end else begin
						val = $urandom_range(0, 200000);
					end
				end
				CFG_FADE_SPEED: begin
					if (pick == 0) begin
						val[SPEED_W-1:0] = '0;
					end else if (pick == 1) begin
						val[SPEED_W-1:0] = '1;
					end else if (pick == 2) begin
						val[SPEED_W-1:0] = SPEED_W'($urandom_range(1, 512));
					end
				end
				CFG_PALETTE_COUNT: begin
					if (pick != 0) begin
						val[CNT_W-1:0] = CNT_W'($urandom_range(1, PAL_DEPTH));
					end
				end
				CFG_UNUSED: ;
				default: begin
					if (pick == 0) begin
						val[COLOR_W-1:0] = BLACK;
					end else if (pick == 1) begin
						val[COLOR_W-1:0] = WHITE;
					end
				end
				endcase
				write_reg(CFG_IDX_W'(r), val);
			end
			calm = (ph >= PHASES - CALM_PHASES);
			if (ph == PRESSURE_PHASE) begin
				long_hold_req = 1'b1;
			end
			for (int w = 0; w < PHASE_WORDS; w++) begin
				pick = $urandom_range(0, 99);
				if (w == 0 || pick >= 92) begin
					kind = REQ_INIT;
				end else if (pick < 62) begin
					kind = REQ_TICK;
				end else if (pick < 68) begin
					kind = REQ_BLINK_START;
				end else if (pick < 73) begin
					kind = REQ_BLINK_STOP;
				end else if (pick < 78) begin
					kind = REQ_FADE_START;
				end else if (pick < 82) begin
					kind = REQ_FADE_STOP;
				end else if (pick < 86) begin
					kind = REQ_LIGHT_OFF;
				end else begin
					kind = REQ_FADE_RESTART;
				end
				case ($urandom_range(0, 3))
				0: dt = DT_W'($urandom_range(0, 255));
				1: dt = $urandom_range(0, 1) ? '1 : '0;
				default: dt = DT_W'($urandom);
				endcase
				send_word(kind, dt, 1'b0, '0);
			end
		end

		req_if.valid <= 1'b0;
		while (pending_light_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (LINGER) @(posedge clk);
		if (mismatches == 0) begin
			$display("led_color_blink_fade_engine: match");
		end else begin
			$display("led_color_blink_fade_engine: mismatch");
		end
		$finish;
	end

endmodule
